/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the same cycle whenever cond holds.
`define SFD_ASSERT_NOW(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that prop holds in the cycle after cond.
`define SFD_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* hdl/sfd_pkg.sv */
package sfd_pkg;

	localparam int DEF_STORE_DEPTH = 262144;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam int DELAY_BITS  = 18;
	localparam int FB_BITS     = 15;
	localparam int WET_BITS    = 16;
	localparam int BEAT_BITS   = 18;
	localparam int DIV_BITS    = 4;
	localparam int FACTOR_BITS = 7;
	localparam int DIV_SHIFT   = 6;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 18;

	localparam int Q15_ONE    = 32768;
	localparam int ROUND_HALF = 16384;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

	localparam cfg_index_t REG_DELAY_SAMPLES = 3'd0;
	localparam cfg_index_t REG_FEEDBACK_GAIN = 3'd1;
	localparam cfg_index_t REG_WET_GAIN      = 3'd2;
	localparam cfg_index_t REG_TEMPO_SYNC    = 3'd3;
	localparam cfg_index_t REG_BEAT_SAMPLES  = 3'd4;
	localparam cfg_index_t REG_SYNC_DIVISION = 3'd5;

	localparam logic [DELAY_BITS-1:0] RST_DELAY_SAMPLES = 18'd48000;
	localparam logic [FB_BITS-1:0]    RST_FEEDBACK_GAIN = 15'd9830;
	localparam logic [WET_BITS-1:0]   RST_WET_GAIN      = 16'd16384;
	localparam logic [BEAT_BITS-1:0]  RST_BEAT_SAMPLES  = 18'd24000;
	localparam logic [DIV_BITS-1:0]   RST_SYNC_DIVISION = 4'd0;

	// Note division factor in 64ths of a beat, 1/32 beat up to 1.5 beats.
	function automatic logic [FACTOR_BITS-1:0] division_factor(input logic [DIV_BITS-1:0] sel);
		case (sel)
			4'd0:    return 7'd2;
			4'd1:    return 7'd3;
			4'd2:    return 7'd4;
			4'd3:    return 7'd6;
			4'd4:    return 7'd8;
			4'd5:    return 7'd12;
			4'd6:    return 7'd16;
			4'd7:    return 7'd24;
			4'd8:    return 7'd32;
			4'd9:    return 7'd48;
			4'd10:   return 7'd64;
			4'd11:   return 7'd96;
			default: return 7'd64;
		endcase
	endfunction

endpackage

/* hdl/sfd_ram.sv */
module sfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/stereo_feedback_delay_unit.sv */
// Stereo feedback echo. Takes one left/right sample pair per cycle unless stalled, and
// presents the mixed pair through the store read, gain products and output register
// stages; one store write port and one registered read port per channel set that pace.
// A result waiting at the output holds the whole pipeline and the input once a second
// result sits behind it. The delay line is not swept after reset: until the write
// pointer has made its first full lap, taps ahead of it read as silence, so samples
// flow from the first cycle out of reset. Write configuration only while no request
// is in flight; a new delay applies to the next request taken.
`include "assert_macros.svh"

module stereo_feedback_delay_unit import sfd_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  cfg_index_t                    cfg_index,
	input  cfg_data_t                     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);

	localparam int SB        = SAMPLE_BITS;
	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int PROD_BITS = BEAT_BITS + FACTOR_BITS;
	localparam int DSEL_BITS = PROD_BITS - DIV_SHIFT;
	localparam int CW        = (AW > DSEL_BITS) ? AW : DSEL_BITS;
	localparam logic [CW-1:0] DMAX = CW'(STORE_DEPTH - 1);
	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);
	localparam logic signed [SB+1:0] SMAX = (SB+2)'((2**(SB-1)) - 1);
	localparam logic signed [SB+1:0] SMIN = -SMAX - (SB+2)'(1);

	function automatic logic signed [SB-1:0] sat(input logic signed [SB+1:0] v);
		if (v > SMAX) begin
			return SB'(SMAX);
		end else if (v < SMIN) begin
			return SB'(SMIN);
		end
		return SB'(v);
	endfunction

	// configuration
	logic [DELAY_BITS-1:0] delay_q;
	logic [FB_BITS-1:0]    fb_q;
	logic [WET_BITS-1:0]   wet_q;
	logic                  tempo_q;
	logic [BEAT_BITS-1:0]  beat_q;
	logic [DIV_BITS-1:0]   div_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RST_DELAY_SAMPLES;
			fb_q    <= RST_FEEDBACK_GAIN;
			wet_q   <= RST_WET_GAIN;
			tempo_q <= 1'b0;
			beat_q  <= RST_BEAT_SAMPLES;
			div_q   <= RST_SYNC_DIVISION;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELAY_SAMPLES: delay_q <= cfg_data[DELAY_BITS-1:0];
				REG_FEEDBACK_GAIN: fb_q    <= cfg_data[FB_BITS-1:0];
				REG_WET_GAIN:      wet_q   <= cfg_data[WET_BITS-1:0];
				REG_TEMPO_SYNC:    tempo_q <= cfg_data[0];
				REG_BEAT_SAMPLES:  beat_q  <= cfg_data[BEAT_BITS-1:0];
				REG_SYNC_DIVISION: div_q   <= cfg_data[DIV_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// delay length and read address
	logic [PROD_BITS-1:0] tempo_prod;
	logic [DSEL_BITS-1:0] d_sel;
	logic [CW-1:0]        d_wide;
	logic [AW-1:0]        d_clamp;
	logic [AW-1:0]        rd_addr;
	logic                 rd_written;
	logic [AW-1:0]        wp_q;
	logic                 wrapped_q;

	assign tempo_prod = PROD_BITS'(beat_q) * PROD_BITS'(division_factor(div_q));
	assign d_sel      = tempo_q ? tempo_prod[PROD_BITS-1:DIV_SHIFT] : DSEL_BITS'(delay_q);
	assign d_wide     = CW'(d_sel);

	always_comb begin
		if (d_wide == '0) begin
			d_clamp = AW'(1);
		end else if (d_wide > DMAX) begin
			d_clamp = LAST;
		end else begin
			d_clamp = AW'(d_wide);
		end
		if (wp_q >= d_clamp) begin
			rd_addr = wp_q - d_clamp;
		end else begin
			rd_addr = AW'((AW+1)'(wp_q) + (AW+1)'(STORE_DEPTH) - (AW+1)'(d_clamp));
		end
		// taps ahead of the pointer hold data only once it has lapped
		rd_written = wrapped_q || (wp_q >= d_clamp);
	end

	// pipeline control
	logic s1_valid;
	logic s2_valid;
	logic out_valid_q;
	logic adv;
	logic accept;

	assign adv      = !s2_valid || !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	logic          wb_valid_q;
	logic [AW-1:0] wb_addr_q;
	logic signed [SB-1:0] wb_left_q;
	logic signed [SB-1:0] wb_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			wb_valid_q  <= 1'b0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
		end else begin
			if (adv) begin
				s1_valid   <= accept;
				s2_valid   <= s1_valid;
				wb_valid_q <= s2_valid;
			end
			if (adv && s2_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (wp_q == LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	// stage 1: store read data, gain products
	logic signed [SB-1:0] in_left_s1, in_right_s1;
	logic [AW-1:0]        rd_s1, wp_s1;
	logic                 written_s1;

	logic signed [SB-1:0]    ram_left, ram_right;
	logic signed [SB-1:0]    del_left, del_right;
	logic [WET_BITS-1:0]     wet_eff, dry_eff;
	logic signed [FB_BITS:0] fb_gain;
	logic signed [WET_BITS:0] wet_gain, dry_gain;

	// stage 2: round, saturate, write back, mix
	logic signed [SB+15:0] fbp_left_s2, fbp_right_s2;
	logic signed [SB+16:0] dryp_left_s2, dryp_right_s2;
	logic signed [SB+16:0] wetp_left_s2, wetp_right_s2;
	logic signed [SB-1:0]  in_left_s2, in_right_s2;
	logic [AW-1:0]         wp_s2;

	logic signed [SB-1:0] st_left, st_right;
	logic signed [SB-1:0] mix_left, mix_right;

	assign wet_eff  = (wet_q > WET_BITS'(Q15_ONE)) ? WET_BITS'(Q15_ONE) : wet_q;
	assign dry_eff  = WET_BITS'(Q15_ONE) - wet_eff;
	assign fb_gain  = $signed({1'b0, fb_q});
	assign wet_gain = $signed({1'b0, wet_eff});
	assign dry_gain = $signed({1'b0, dry_eff});

	// forward the writes the store read could not see yet
	always_comb begin
		if (s2_valid && wp_s2 == rd_s1) begin
			del_left  = st_left;
			del_right = st_right;
		end else if (wb_valid_q && wb_addr_q == rd_s1) begin
			del_left  = wb_left_q;
			del_right = wb_right_q;
		end else if (written_s1) begin
			del_left  = ram_left;
			del_right = ram_right;
		end else begin
			del_left  = '0;
			del_right = '0;
		end
	end

	logic signed [SB+15:0] fb_sum_left, fb_sum_right;
	logic signed [SB+16:0] mix_sum_left, mix_sum_right;
	logic signed [SB:0]    fb_rnd_left, fb_rnd_right;
	logic signed [SB+1:0]  mix_rnd_left, mix_rnd_right;

	always_comb begin
		fb_sum_left   = fbp_left_s2 + (SB+16)'(ROUND_HALF);
		fb_sum_right  = fbp_right_s2 + (SB+16)'(ROUND_HALF);
		fb_rnd_left   = $signed(fb_sum_left[SB+15:15]);
		fb_rnd_right  = $signed(fb_sum_right[SB+15:15]);
		st_left       = sat((SB+2)'(in_left_s2) + (SB+2)'(fb_rnd_left));
		st_right      = sat((SB+2)'(in_right_s2) + (SB+2)'(fb_rnd_right));
		mix_sum_left  = dryp_left_s2 + wetp_left_s2 + (SB+17)'(ROUND_HALF);
		mix_sum_right = dryp_right_s2 + wetp_right_s2 + (SB+17)'(ROUND_HALF);
		mix_rnd_left  = $signed(mix_sum_left[SB+16:15]);
		mix_rnd_right = $signed(mix_sum_right[SB+16:15]);
		mix_left      = sat(mix_rnd_left);
		mix_right     = sat(mix_rnd_right);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_left_s1    <= left_in;
			in_right_s1   <= right_in;
			rd_s1         <= rd_addr;
			wp_s1         <= wp_q;
			written_s1    <= rd_written;

			fbp_left_s2   <= del_left * fb_gain;
			fbp_right_s2  <= del_right * fb_gain;
			dryp_left_s2  <= in_left_s1 * dry_gain;
			dryp_right_s2 <= in_right_s1 * dry_gain;
			wetp_left_s2  <= del_left * wet_gain;
			wetp_right_s2 <= del_right * wet_gain;
			in_left_s2    <= in_left_s1;
			in_right_s2   <= in_right_s1;
			wp_s2         <= wp_s1;

			wb_addr_q     <= wp_s2;
			wb_left_q     <= st_left;
			wb_right_q    <= st_right;
		end
		if (adv && s2_valid) begin
			left_out  <= mix_left;
			right_out <= mix_right;
		end
	end

	assign out_valid = out_valid_q;

	sfd_ram #(
		.WIDTH(SB),
		.DEPTH(STORE_DEPTH)
	) u_left_store (
		.clk  (clk),
		.we   (adv && s2_valid),
		.waddr(wp_s2),
		.wdata(st_left),
		.re   (adv),
		.raddr(rd_addr),
		.rdata(ram_left)
	);

	sfd_ram #(
		.WIDTH(SB),
		.DEPTH(STORE_DEPTH)
	) u_right_store (
		.clk  (clk),
		.we   (adv && s2_valid),
		.waddr(wp_s2),
		.wdata(st_right),
		.re   (adv),
		.raddr(rd_addr),
		.rdata(ram_right)
	);

	`SFD_ASSERT_NOW(a_tap_not_head, s1_valid, rd_s1 != wp_s1, "read tap hits write slot")
	`SFD_ASSERT_NEXT(a_lap_sticky, wrapped_q, wrapped_q, "lap flag dropped")
	`SFD_ASSERT_NEXT(a_result_lands, adv && s2_valid, out_valid_q, "result lost at output")
	`SFD_ASSERT_NEXT(a_ptr_moves, accept, wp_q != $past(wp_q), "pointer did not advance")

endmodule
